// ----- rtl/core/tcw_pkg.sv -----
// tcw_pkg: shared types and constants of the text console writer.
// Operation and control codes, cell constants, controller states and the
// command/status structs between tcw_ctrl and tcw_datapath. No dependencies.
package tcw_pkg;

   localparam int CELL_W      = 16;
   localparam int CHAR_W      = 8;
   localparam int COLOR_W     = 4;
   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int TAB_STEP    = 4;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_READ  = 2'd1,
      OP_SET   = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   localparam logic [CHAR_W-1:0] CH_BS      = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NL      = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

   localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;
   localparam logic [CELL_W-1:0] CELL_BLANK = 16'h0020;

   localparam logic [CSR_INDEX_W-1:0] CSR_FOREGROUND = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND = 2'd1;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CALC,
      ST_PUT,
      ST_READ,
      ST_SCROLL,
      ST_CLEAR,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      SW_NONE,
      SW_INIT,
      SW_CLEAR,
      SW_SCROLL
   } sweep_type;

   typedef struct packed {
      logic      load_item;
      logic      calc;
      logic      put_commit;
      logic      read_issue;
      sweep_type sweep;
      logic      load_rsp;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   scroll;
      logic   sweep_done;
   } stat_type;

endpackage

// ----- rtl/core/tcw_ctrl.sv -----
// tcw_ctrl: sequencing state machine of the text console writer.
// Drives the datapath commands and owns the result valid flag.
// Depends on tcw_pkg.
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:   if (stat.sweep_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_tvalid) state_in = ST_CALC;
         ST_CALC: begin
            unique case (stat.op)
               OP_PUT:   state_in = ST_PUT;
               OP_READ:  state_in = ST_READ;
               OP_SET:   state_in = ST_RESP;
               OP_CLEAR: state_in = ST_CLEAR;
               default:  state_in = ST_RESP;
            endcase
         end
         ST_PUT:    state_in = stat.scroll ? ST_SCROLL : ST_RESP;
         ST_READ:   state_in = ST_RESP;
         ST_SCROLL: if (stat.sweep_done) state_in = ST_RESP;
         ST_CLEAR:  if (stat.sweep_done) state_in = ST_RESP;
         ST_RESP:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_INIT;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.sweep  = SW_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_INIT:   cmd.sweep = SW_INIT;
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_item = req_tvalid;
         end
         ST_CALC:   cmd.calc = 1'b1;
         ST_PUT:    cmd.put_commit = 1'b1;
         ST_READ:   cmd.read_issue = 1'b1;
         ST_SCROLL: cmd.sweep = SW_SCROLL;
         ST_CLEAR:  cmd.sweep = SW_CLEAR;
         ST_RESP:   cmd.load_rsp = rsp_free;
         default:   cmd.sweep = SW_NONE;
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/tcw_datapath.sv -----
// tcw_datapath: screen store, cursor, colour registers and result register.
// Executes the commands of tcw_ctrl: cursor update, cell write/read, sweeps.
// Depends on tcw_pkg.
module tcw_datapath
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  op_type                 item_operation,
   input  logic [CHAR_W-1:0]      item_character,
   input  logic [ROW_FIELD_W-1:0] item_row,
   input  logic [COL_FIELD_W-1:0] item_col,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]     csr_data,
   output logic [CELL_W-1:0]      rsp_cell_data,
   output logic [COL_FIELD_W-1:0] rsp_cursor_col,
   output logic [ROW_FIELD_W-1:0] rsp_cursor_row
);

   localparam int CELLS        = COLUMNS * ROWS;
   localparam int SCROLL_CELLS = CELLS - COLUMNS;
   localparam int ADDR_W       = $clog2(CELLS);
   localparam int CNT_W        = $clog2(CELLS + 1);
   localparam int ROW_W        = $clog2(ROWS);
   localparam int COL_W        = $clog2(COLUMNS);
   localparam int RX_W         = ROW_W + 1;
   localparam int CX_W         = COL_W + 1;
   localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
   localparam logic [RX_W-1:0]  ROWS_X    = RX_W'(ROWS);
   localparam logic [CX_W-1:0]  COLUMNS_X = CX_W'(COLUMNS);

   logic [CELL_W-1:0] mem [0:CELLS-1];

   op_type             op_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic [ROW_W-1:0]   row_ff, row_clamp;
   logic [COL_W-1:0]   col_ff, col_clamp;
   logic [ROW_W-1:0]   crow_ff, crow_in;
   logic [COL_W-1:0]   ccol_ff, ccol_in;
   logic [COLOR_W-1:0] fg_ff, bg_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, cnt_prev, cnt_fwd;

   logic [ADDR_W-1:0]  addr_ff;
   logic [ROW_W-1:0]   pend_row_ff;
   logic [COL_W-1:0]   pend_col_ff;
   logic               pend_we_ff, pend_scroll_ff;
   logic [CELL_W-1:0]  wdata_ff, rdata_ff;

   logic [CELL_W-1:0]      rsp_cell_ff;
   logic [COL_FIELD_W-1:0] rsp_col_ff;
   logic [ROW_FIELD_W-1:0] rsp_row_ff;

   logic [CX_W-1:0]    col_inc, col_tab;
   logic [RX_W-1:0]    row_inc, nrow;
   logic [COL_W-1:0]   ncol, wr_col, calc_col;
   logic [ROW_W-1:0]   nrow_fin, wr_row, calc_row;
   logic               wr_en, scroll;
   logic [CHAR_W-1:0]  wr_char;
   logic [ADDR_W-1:0]  calc_addr;

   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [CELL_W-1:0]  mem_wdata;
   logic               sweep_done;

   // clamp of the addressed row and column
   assign row_clamp = (32'(item_row) > 32'(ROWS - 1)) ? ROW_LAST : ROW_W'(item_row);
   assign col_clamp = (32'(item_col) > 32'(COLUMNS - 1)) ? COL_LAST : COL_W'(item_col);

   // cursor movement for a put
   always_comb begin
      col_inc = {1'b0, ccol_ff} + CX_W'(1);
      col_tab = {1'b0, ccol_ff} + CX_W'(TAB_STEP);
      row_inc = {1'b0, crow_ff} + RX_W'(1);
      nrow    = {1'b0, crow_ff};
      ncol    = ccol_ff;
      wr_row  = crow_ff;
      wr_col  = ccol_ff;
      wr_en   = 1'b0;
      wr_char = char_ff;
      unique case (char_ff)
         CH_NL: begin
            nrow = row_inc;
            ncol = '0;
         end
         CH_CR: ncol = '0;
         CH_TAB: begin
            if (col_tab >= COLUMNS_X) begin
               ncol = COL_W'(col_tab - COLUMNS_X);
               nrow = row_inc;
            end else begin
               ncol = COL_W'(col_tab);
            end
         end
         CH_BS: begin
            if (crow_ff != '0 || ccol_ff != '0) begin
               wr_en   = 1'b1;
               wr_char = SPACE_CHAR;
               if (ccol_ff == '0) begin
                  ncol = COL_LAST;
                  nrow = {1'b0, crow_ff} - RX_W'(1);
               end else begin
                  ncol = ccol_ff - COL_W'(1);
               end
               wr_row = nrow[ROW_W-1:0];
               wr_col = ncol;
            end
         end
         default: begin
            wr_en = 1'b1;
            if (col_inc == COLUMNS_X) begin
               ncol = '0;
               nrow = row_inc;
            end else begin
               ncol = COL_W'(col_inc);
            end
         end
      endcase
      scroll   = (nrow == ROWS_X);
      nrow_fin = scroll ? ROW_LAST : nrow[ROW_W-1:0];
   end

   assign calc_row  = (op_ff == OP_READ) ? row_ff : wr_row;
   assign calc_col  = (op_ff == OP_READ) ? col_ff : wr_col;
   assign calc_addr = ADDR_W'(32'(calc_row) * COLUMNS + 32'(calc_col));

   // sweeps: fill at count; scroll reads count+COLUMNS and writes count-1
   assign cnt_prev = cnt_ff - CNT_W'(1);
   assign cnt_fwd  = cnt_ff + CNT_W'(COLUMNS);
   assign cnt_in   = (cmd.sweep == SW_NONE) ? '0 : cnt_ff + CNT_W'(1);

   always_comb begin
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_waddr  = addr_ff;
      mem_raddr  = addr_ff;
      mem_wdata  = wdata_ff;
      sweep_done = 1'b0;
      unique case (cmd.sweep)
         SW_INIT: begin
            mem_we     = 1'b1;
            mem_waddr  = cnt_ff[ADDR_W-1:0];
            mem_wdata  = CELL_RESET;
            sweep_done = (cnt_ff == CNT_W'(CELLS - 1));
         end
         SW_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = cnt_ff[ADDR_W-1:0];
            mem_wdata  = {bg_ff, fg_ff, SPACE_CHAR};
            sweep_done = (cnt_ff == CNT_W'(CELLS - 1));
         end
         SW_SCROLL: begin
            mem_we     = (cnt_ff != '0);
            mem_waddr  = cnt_prev[ADDR_W-1:0];
            mem_wdata  = (cnt_prev < CNT_W'(SCROLL_CELLS)) ? rdata_ff : CELL_BLANK;
            mem_re     = (cnt_ff < CNT_W'(SCROLL_CELLS));
            mem_raddr  = cnt_fwd[ADDR_W-1:0];
            sweep_done = (cnt_ff == CNT_W'(CELLS));
         end
         default: begin
            mem_we = cmd.put_commit && pend_we_ff;
            mem_re = cmd.read_issue;
         end
      endcase
   end

   assign stat = '{op: op_ff, scroll: pend_scroll_ff, sweep_done: sweep_done};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      crow_in = crow_ff;
      ccol_in = ccol_ff;
      if (cmd.calc && op_ff == OP_SET) begin
         crow_in = row_ff;
         ccol_in = col_ff;
      end else if (cmd.put_commit) begin
         crow_in = pend_row_ff;
         ccol_in = pend_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crow_ff <= '0;
         ccol_ff <= '0;
         cnt_ff  <= '0;
         fg_ff   <= 4'd7;
         bg_ff   <= 4'd0;
      end else begin
         crow_ff <= crow_in;
         ccol_ff <= ccol_in;
         cnt_ff  <= cnt_in;
         if (csr_write) begin
            case (csr_index)
               CSR_FOREGROUND: fg_ff <= csr_data;
               CSR_BACKGROUND: bg_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= item_operation;
         char_ff <= item_character;
         row_ff  <= row_clamp;
         col_ff  <= col_clamp;
      end
      if (cmd.calc) begin
         addr_ff        <= calc_addr;
         pend_row_ff    <= nrow_fin;
         pend_col_ff    <= ncol;
         pend_we_ff     <= wr_en;
         pend_scroll_ff <= scroll;
         wdata_ff       <= {bg_ff, fg_ff, wr_char};
      end
      if (cmd.load_rsp) begin
         rsp_cell_ff <= (op_ff == OP_READ) ? rdata_ff : '0;
         rsp_col_ff  <= COL_FIELD_W'(ccol_ff);
         rsp_row_ff  <= ROW_FIELD_W'(crow_ff);
      end
   end

   assign rsp_cell_data  = rsp_cell_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;

`ifndef SYNTHESIS
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (ccol_ff <= COL_LAST) && (crow_ff <= ROW_LAST))
      else $error("cursor outside the screen");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(mem_waddr) < CELLS))
      else $error("cell write outside the store");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_re |-> (32'(mem_raddr) < CELLS))
      else $error("cell read outside the store");

   a_commit_after_calc: assert property (@(posedge clock) disable iff (reset)
      cmd.put_commit |-> $past(cmd.calc))
      else $error("put committed without a preceding calculation");
`endif

endmodule

// ----- rtl/core/text_console_writer.sv -----
// text_console_writer: top level of the text console writer.
// Joins the controller tcw_ctrl and the datapath tcw_datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// req_*  : one command item per handshake (put character, read cell,
//          set cursor, clear screen).
// rsp_*  : one result item per command: cell read (zero unless a read) and
//          the cursor column and row after the command.
// csr_*  : colour writes (index 0 foreground, 1 background); always ready,
//          to be written only while the block is idle.
// Timing: one command at a time; the next item is accepted once the result
//   of the previous one is in the output register. A put past the last cell
//   adds a scroll pass and clear screen a fill pass, one cell per cycle
//   through the store.
// Reset: the store is filled with grey spaces, one cell per cycle;
//   req_tready stays low meanwhile.
// Stall: the result waits in an output register; the next command is accepted
//   meanwhile and its own result is held until the first is taken.
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [23:0]            req_tdata,  // operation, character, row, col
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,  // cell_data, cursor_col, cursor_row
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]     csr_data
);

   cmd_type                cmd;
   stat_type               stat;
   logic [CELL_W-1:0]      cell_data;
   logic [COL_FIELD_W-1:0] cursor_col;
   logic [ROW_FIELD_W-1:0] cursor_row;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {4'b0, cursor_row, cursor_col, cell_data};

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .item_operation (op_type'(req_tdata[1:0])),
      .item_character (req_tdata[9:2]),
      .item_row       (req_tdata[14:10]),
      .item_col       (req_tdata[21:15]),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_cell_data  (cell_data),
      .rsp_cursor_col (cursor_col),
      .rsp_cursor_row (cursor_row)
   );

endmodule

// ----- dv/tb_text_console_writer.sv -----
// tb_text_console_writer: self-checking testbench for the text console writer.
// Drives command items and colour writes, predicts every result with its own screen
// model in a small scoreboard class. Depends on tcw_pkg and text_console_writer.
module tb_text_console_writer;
   import tcw_pkg::*;

   localparam int SCREEN_COLS     = 80;
   localparam int SCREEN_ROWS     = 25;
   localparam int SCREEN_CELLS    = SCREEN_COLS * SCREEN_ROWS;
   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 11;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 30000;
   localparam int COLOUR_EVERY    = 250;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   localparam logic [CHAR_W-1:0] PRINT_FIRST = 8'h20;
   localparam logic [CHAR_W-1:0] PRINT_LAST  = 8'h7e;

   typedef struct packed {
      logic [COL_FIELD_W-1:0] col;
      logic [ROW_FIELD_W-1:0] row;
      logic [CHAR_W-1:0]      character;
      op_type                 op;
   } console_cmd_t;

   typedef struct packed {
      logic [ROW_FIELD_W-1:0] row;
      logic [COL_FIELD_W-1:0] col;
      logic [CELL_W-1:0]      cell_data;
   } console_rsp_t;

   class console_scoreboard;
      logic [CELL_W-1:0]  cells [SCREEN_CELLS];
      int unsigned        cursor;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      console_rsp_t       expected_q [$];
      int                 errors;

      function new();
         foreach (cells[i]) cells[i] = CELL_RESET;
         cursor = 0;
         fg     = 4'd7;
         bg     = 4'd0;
         errors = 0;
      endfunction

      function void note_colour(logic [CSR_INDEX_W-1:0] idx, logic [COLOR_W-1:0] value);
         if (idx == CSR_FOREGROUND)
            fg = value;
         else if (idx == CSR_BACKGROUND)
            bg = value;
      endfunction

      function logic [CELL_W-1:0] coloured(logic [CHAR_W-1:0] ch);
         return {bg, fg, ch};
      endfunction

      function int unsigned clamp_offset(logic [ROW_FIELD_W-1:0] r,
                                         logic [COL_FIELD_W-1:0] c);
         int unsigned rr;
         int unsigned cc;
         rr = (r > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : r;
         cc = (c > SCREEN_COLS - 1) ? SCREEN_COLS - 1 : c;
         return rr * SCREEN_COLS + cc;
      endfunction

      function void put_char(logic [CHAR_W-1:0] ch);
         int unsigned moved;
         moved = cursor;
         case (ch)
            CH_NL:  moved = (cursor / SCREEN_COLS + 1) * SCREEN_COLS;
            CH_CR:  moved = (cursor / SCREEN_COLS) * SCREEN_COLS;
            CH_TAB: moved = cursor + TAB_STEP;
            CH_BS: begin
               if (cursor == 0)
                  return;
               moved = cursor - 1;
               cells[moved] = coloured(SPACE_CHAR);
            end
            default: begin
               cells[cursor] = coloured(ch);
               moved = cursor + 1;
            end
         endcase
         if (moved > SCREEN_CELLS - 1) begin
            for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
               cells[i] = cells[i + SCREEN_COLS];
            for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
               cells[i] = CELL_BLANK;
            moved -= SCREEN_COLS;
         end
         cursor = moved;
      endfunction

      function void note_command(console_cmd_t cmd);
         console_rsp_t want;
         want.cell_data = '0;
         case (cmd.op)
            OP_PUT:  put_char(cmd.character);
            OP_READ: want.cell_data = cells[clamp_offset(cmd.row, cmd.col)];
            OP_SET:  cursor = clamp_offset(cmd.row, cmd.col);
            default: foreach (cells[i]) cells[i] = coloured(SPACE_CHAR);
         endcase
         want.col = COL_FIELD_W'(cursor % SCREEN_COLS);
         want.row = ROW_FIELD_W'(cursor / SCREEN_COLS);
         expected_q.push_back(want);
      endfunction

      task report_mismatch(string field, int unsigned got, int unsigned want);
         $display("mismatch in %s at %0t: got %0h, want %0h", field, $time, got, want);
         errors++;
      endtask

      task check_result(logic [31:0] data);
         console_rsp_t got;
         console_rsp_t want;
         got = data[$bits(console_rsp_t)-1:0];
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected item", data, 0);
            return;
         end
         want = expected_q.pop_front();
         if (got.cell_data !== want.cell_data)
            report_mismatch("cell_data", got.cell_data, want.cell_data);
         if (got.col !== want.col)
            report_mismatch("cursor_col", got.col, want.col);
         if (got.row !== want.row)
            report_mismatch("cursor_row", got.row, want.row);
      endtask
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            req_tdata  = '0;  // operation, character, row, col
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [31:0]            rsp_tdata;        // cell_data, cursor_col, cursor_row
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [COLOR_W-1:0]     csr_data   = '0;

   console_scoreboard board;
   int send_idle     = 0;
   int recv_idle     = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   text_console_writer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // result side: check, then decide tready for the next edge
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata);
      if (hold_requests != holds_served) begin
         holds_served++;
         hold_left = RSP_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic console_cmd_t make_cmd(op_type op, int ch, int r, int c);
      console_cmd_t cmd;
      cmd.op        = op;
      cmd.character = CHAR_W'(ch);
      cmd.row       = ROW_FIELD_W'(r);
      cmd.col       = COL_FIELD_W'(c);
      return cmd;
   endfunction

   function automatic logic [CHAR_W-1:0] random_char();
      int pick;
      pick = $urandom_range(99);
      if (pick < 65)
         return CHAR_W'($urandom_range(PRINT_LAST, PRINT_FIRST));
      if (pick < 85) begin
         case ($urandom_range(3))
            0:       return CH_BS;
            1:       return CH_TAB;
            2:       return CH_NL;
            default: return CH_CR;
         endcase
      end
      return CHAR_W'($urandom_range(255));
   endfunction

   function automatic console_cmd_t random_cmd();
      int     pick;
      int     r;
      int     c;
      op_type op;
      pick = $urandom_range(999);
      r = ($urandom_range(99) < 85) ? $urandom_range(SCREEN_ROWS - 1) : $urandom_range(31);
      c = ($urandom_range(99) < 85) ? $urandom_range(SCREEN_COLS - 1) : $urandom_range(127);
      if (pick < 620)
         op = OP_PUT;
      else if (pick < 820)
         op = OP_READ;
      else if (pick < 990)
         op = OP_SET;
      else
         op = OP_CLEAR;
      return make_cmd(op, (op == OP_PUT) ? random_char() : $urandom_range(255), r, c);
   endfunction

   task automatic send_item(console_cmd_t cmd);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, cmd};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_command(cmd);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [COLOR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      board.note_colour(idx, value);
   endtask

   task automatic set_colours(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
      drain_results();
      write_csr(CSR_FOREGROUND, fg);
      write_csr(CSR_BACKGROUND, bg);
      if ($urandom_range(2) == 0)
         write_csr($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B, COLOR_W'($urandom));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // mostly text lines at a random place, ending in return and newline, plus noise
   task automatic run_traffic(int items, int s_idle, int r_idle, bit hold);
      int sent;
      int next_colour;
      int len;
      sent        = 0;
      next_colour = COLOUR_EVERY;
      send_idle   = s_idle;
      recv_idle   = r_idle;
      if (hold)
         hold_requests++;
      while (sent < items) begin
         if (sent >= next_colour) begin
            set_colours(COLOR_W'($urandom), COLOR_W'($urandom));
            next_colour += COLOUR_EVERY;
         end
         if ($urandom_range(99) < 8) begin
            len = $urandom_range(90, 1);
            send_item(make_cmd(OP_SET, 0, $urandom_range(SCREEN_ROWS - 1),
                               $urandom_range(SCREEN_COLS - 1)));
            repeat (len)
               send_item(make_cmd(OP_PUT, ($urandom_range(19) == 0) ? CH_TAB :
                                  $urandom_range(PRINT_LAST, PRINT_FIRST), 0, 0));
            send_item(make_cmd(OP_PUT, CH_CR, 0, 0));
            send_item(make_cmd(OP_PUT, CH_NL, 0, 0));
            sent += len + 3;
         end else begin
            send_item(random_cmd());
            sent++;
         end
      end
   endtask

   initial begin
      board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_idle = 20;
      recv_idle = 20;
      send_item(make_cmd(OP_READ, 0, 0, 0));
      send_item(make_cmd(OP_READ, 0, 31, 127));
      send_item(make_cmd(OP_PUT, 8'h41, 0, 0));
      send_item(make_cmd(OP_PUT, 8'hff, 0, 0));
      send_item(make_cmd(OP_PUT, 8'h00, 0, 0));
      send_item(make_cmd(OP_PUT, CH_BS, 0, 0));
      send_item(make_cmd(OP_PUT, CH_TAB, 0, 0));
      send_item(make_cmd(OP_PUT, CH_CR, 0, 0));
      send_item(make_cmd(OP_SET, 0, 0, 0));
      send_item(make_cmd(OP_PUT, CH_BS, 0, 0));
      send_item(make_cmd(OP_PUT, CH_NL, 0, 0));
      send_item(make_cmd(OP_SET, 0, 20, 100));
      set_colours(4'hf, 4'h0);
      // running off the end scrolls, by a drawn character, a tab and a newline
      send_item(make_cmd(OP_SET, 0, 31, 127));
      send_item(make_cmd(OP_PUT, 8'h5a, 0, 0));
      send_item(make_cmd(OP_READ, 0, 23, 79));
      send_item(make_cmd(OP_READ, 0, 24, 0));
      send_item(make_cmd(OP_SET, 0, 24, 78));
      send_item(make_cmd(OP_PUT, CH_TAB, 0, 0));
      send_item(make_cmd(OP_SET, 0, 24, 5));
      send_item(make_cmd(OP_PUT, CH_NL, 0, 0));
      set_colours(4'h0, 4'hf);
      send_item(make_cmd(OP_PUT, CH_BS, 0, 0));
      send_item(make_cmd(OP_READ, 0, 23, 79));
      send_item(make_cmd(OP_CLEAR, 0, 0, 0));
      send_item(make_cmd(OP_READ, 0, 12, 40));
      send_item(make_cmd(OP_PUT, 8'h7e, 0, 0));

      set_colours(4'hf, 4'hf);
      run_traffic(667, 37, 73, 1'b1);
      set_colours(4'h0, 4'h0);
      run_traffic(667, 73, 37, 1'b0);
      set_colours(4'hf, 4'h0);
      run_traffic(666, 0, 0, 1'b1);

      drain_results();
      if (board.errors == 0 && board.expected_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/tcw_pkg.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_datapath.sv
rtl/core/text_console_writer.sv
dv/tb_text_console_writer.sv
